// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the core top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/cst_pkg.sv =====
package cst_pkg;

  localparam longint unsigned DEF_MAX_TEXT_LEN = 64'd65536;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned RUN_MAX = 3;

  typedef enum logic [2:0] {
    LM_SPACE     = 3'd0,
    LM_IDENT     = 3'd1,
    LM_STRING    = 3'd2,
    LM_NUMBER    = 3'd3,
    LM_DIRECTIVE = 3'd4
  } lex_mode_t;

  typedef enum logic [3:0] {
    CL_NEWLINE = 4'd0,
    CL_SPACE   = 4'd1,
    CL_LETTER  = 4'd2,
    CL_DIGIT   = 4'd3,
    CL_HASH    = 4'd4,
    CL_PERIOD  = 4'd5,
    CL_QUOTE   = 4'd6,
    CL_SYMBOL  = 4'd7,
    CL_UNKNOWN = 4'd8
  } char_class_t;

  typedef enum logic [3:0] {
    K_OTHER     = 4'd0,
    K_IDENT     = 4'd1,
    K_STRING    = 4'd2,
    K_NUMBER    = 4'd3,
    K_DIRECTIVE = 4'd4,
    K_LPAREN    = 4'd5,
    K_RPAREN    = 4'd6,
    K_LBRACE    = 4'd7,
    K_RBRACE    = 4'd8,
    K_SEMI      = 4'd9,
    K_EOT       = 4'd10,
    K_ERROR     = 4'd11
  } tok_kind_t;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_PERIOD  = 8'h2E;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LESS    = 8'h3C;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] token_offset;
    logic [15:0] token_length;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] offset;
    logic [15:0] length;
  } token_t;

  // Tokens caused by one character, in order; count is never zero in the queue.
  typedef struct packed {
    logic [1:0]             count;
    token_t [RUN_MAX-1:0]   tok;
  } run_t;

  typedef struct packed {
    logic push;
    run_t run;
  } q_push_t;

  typedef struct packed {
    logic valid;
    run_t run;
  } q_head_t;

  function automatic char_class_t char_class(input logic [7:0] c);
    char_class_t cl;
    if (c == CH_NEWLINE) begin
      cl = CL_NEWLINE;
    end else if (c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D || c == 8'h20) begin
      cl = CL_SPACE;
    end else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
      cl = CL_LETTER;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      cl = CL_DIGIT;
    end else if (c == CH_HASH) begin
      cl = CL_HASH;
    end else if (c == CH_PERIOD) begin
      cl = CL_PERIOD;
    end else if (c == CH_QUOTE) begin
      cl = CL_QUOTE;
    end else if (c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACE || c == CH_RBRACE ||
                 c == CH_LESS || c == CH_GREATER || c == CH_COMMA || c == CH_BSLASH ||
                 c == CH_SEMI) begin
      cl = CL_SYMBOL;
    end else begin
      cl = CL_UNKNOWN;
    end
    return cl;
  endfunction

  function automatic tok_kind_t symbol_kind(input logic [7:0] c);
    tok_kind_t k;
    unique case (c)
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      CH_SEMI:   k = K_SEMI;
      default:   k = K_OTHER;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/core/cst_front.sv =====
module cst_front #(
  parameter longint unsigned MAX_TEXT_LEN = cst_pkg::DEF_MAX_TEXT_LEN
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  cst_pkg::in_item_t  in_data,
  output cst_pkg::q_push_t   q_push
);
  import cst_pkg::*;

  localparam logic [15:0] POS_LIM =
    (MAX_TEXT_LEN - 64'd1 > 64'd65535) ? 16'hFFFF : 16'(MAX_TEXT_LEN - 64'd1);

  lex_mode_t   mode_r, mode_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] start_r, start_nxt;

  char_class_t cls;
  tok_kind_t   sym;
  logic [3:0]  pend_kind;
  logic        accept;
  logic [15:0] pos_inc;
  logic [15:0] span_ex;
  logic [16:0] span_sum;
  logic [15:0] span_in;

  lex_mode_t   mode_mid;
  logic [15:0] start_mid;
  logic [15:0] flush_len;
  logic [1:0]  main_cnt;
  token_t      main0, main1;
  logic        flush_en;
  run_t        run;

  assign accept    = in_valid && !in_stall;
  assign cls       = char_class(in_data.char_code);
  assign sym       = symbol_kind(in_data.char_code);
  assign pend_kind = {1'b0, mode_r};
  assign pos_inc   = (pos_r < POS_LIM) ? pos_r + 16'd1 : POS_LIM;
  assign span_ex   = (pos_r >= start_r) ? pos_r - start_r : 16'd0;
  assign span_sum  = {1'b0, span_ex} + 17'd1;
  assign span_in   = span_sum[16] ? 16'hFFFF : span_sum[15:0];

  // Next mode and pending start after this character, before end-of-text handling.
  always_comb begin
    mode_mid  = mode_r;
    start_mid = start_r;
    flush_len = span_in;
    unique case (mode_r)
      LM_IDENT, LM_NUMBER: begin
        if (!(cls == CL_DIGIT || (cls == CL_LETTER && mode_r == LM_IDENT))) begin
          mode_mid = LM_SPACE;
        end
      end
      LM_STRING, LM_DIRECTIVE: begin
        if (cls == CL_UNKNOWN || (mode_r == LM_STRING && cls == CL_QUOTE) ||
            (mode_r == LM_DIRECTIVE && cls == CL_NEWLINE)) begin
          mode_mid = LM_SPACE;
        end
      end
      default: begin
        mode_mid = LM_SPACE;
        start_mid = pos_r;
        flush_len = 16'd1;
        unique case (cls)
          CL_HASH:   mode_mid = LM_DIRECTIVE;
          CL_LETTER: mode_mid = LM_IDENT;
          CL_QUOTE:  mode_mid = LM_STRING;
          CL_DIGIT:  mode_mid = LM_NUMBER;
          default:   mode_mid = LM_SPACE;
        endcase
      end
    endcase
  end

  // Next state: end of text drops back to reset values.
  always_comb begin
    if (in_data.end_of_text) begin
      mode_nxt  = LM_SPACE;
      pos_nxt   = 16'd0;
      start_nxt = 16'd0;
    end else begin
      mode_nxt  = mode_mid;
      pos_nxt   = pos_inc;
      start_nxt = start_mid;
    end
  end

  // Tokens raised by this character.
  always_comb begin
    main_cnt = 2'd0;
    main0    = '{kind: K_ERROR, offset: start_r, length: span_in};
    main1    = '{kind: sym, offset: pos_r, length: 16'd1};
    unique case (mode_r)
      LM_IDENT, LM_NUMBER: begin
        if (cls == CL_DIGIT || (cls == CL_LETTER && mode_r == LM_IDENT)) begin
          main_cnt = 2'd0;
        end else if (cls == CL_NEWLINE || cls == CL_SPACE) begin
          main_cnt = 2'd1;
          main0.kind = pend_kind;
        end else if (cls == CL_SYMBOL) begin
          main_cnt = 2'd2;
          main0.kind = pend_kind;
          main0.length = span_ex;
        end else begin
          main_cnt = 2'd1;
        end
      end
      LM_STRING, LM_DIRECTIVE: begin
        if (cls == CL_UNKNOWN) begin
          main_cnt = 2'd1;
        end else if ((mode_r == LM_STRING && cls == CL_QUOTE) ||
                     (mode_r == LM_DIRECTIVE && cls == CL_NEWLINE)) begin
          main_cnt = 2'd1;
          main0.kind = pend_kind;
        end
      end
      default: begin
        main0.offset = pos_r;
        main0.length = 16'd1;
        unique case (cls)
          CL_SYMBOL: begin
            main_cnt = 2'd1;
            main0.kind = sym;
          end
          CL_PERIOD, CL_UNKNOWN: main_cnt = 2'd1;
          default: main_cnt = 2'd0;
        endcase
      end
    endcase

    flush_en  = in_data.end_of_text && (mode_mid != LM_SPACE);
    run.count = main_cnt;
    run.tok   = '0;
    run.tok[0] = main0;
    run.tok[1] = main1;
    if (in_data.end_of_text) begin
      if (flush_en) begin
        run.tok[run.count] = '{kind: {1'b0, mode_mid}, offset: start_mid, length: flush_len};
        run.count = run.count + 2'd1;
      end
      run.tok[run.count] = '{kind: K_EOT, offset: pos_inc, length: 16'd0};
      run.count = run.count + 2'd1;
    end
  end

  assign q_push.push = accept && (run.count != 2'd0);
  assign q_push.run  = run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= LM_SPACE;
      pos_r   <= 16'd0;
      start_r <= 16'd0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

// ===== rtl/core/cst_queue.sv =====
module cst_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  cst_pkg::q_push_t  q_push,
  input  logic              pop,
  output cst_pkg::q_head_t  q_head,
  output logic              full
);
  import cst_pkg::*;

  localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

  run_t              mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              do_push, do_pop;

  assign full    = (fill_r == FILL_W'(QUEUE_DEPTH));
  assign do_push = q_push.push && !full;
  assign do_pop  = pop && (fill_r != '0);

  assign q_head.valid = (fill_r != '0);
  assign q_head.run   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_push.run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

// ===== rtl/core/cst_back.sv =====
module cst_back (
  input  logic               clk,
  input  logic               rst_n,
  input  cst_pkg::q_head_t   q_head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output cst_pkg::out_item_t out_data
);
  import cst_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  out_item_t  data_r;
  logic       load;
  logic       is_last;
  token_t     sel;

  assign load    = !valid_r || !out_stall;
  assign sel     = q_head.run.tok[idx_r];
  assign is_last = (idx_r == q_head.run.count - 2'd1);
  assign pop     = load && q_head.valid && is_last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = q_head.valid;
      if (q_head.valid) begin
        idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_head.valid) begin
      data_r <= '{token_kind: sel.kind, token_offset: sel.offset,
                  token_length: sel.length, last_of_run: is_last};
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== rtl/core/char_stream_tokenizer_core.sv =====
// Path: an accepted character's tokens are written into the run queue as one run; the
// output register loads them from the queue head one token at a time. Throughput: one
// character per cycle unless in_stall; the output register sends one token per cycle
// unless out_stall, so a character raising k tokens occupies it for all k, and a four-entry
// run queue between lexer and output absorbs such bursts before in_stall rises.
// Reset: synchronous active-low rst_n empties the queue and returns the lexer to space mode.
module char_stream_tokenizer_core #(
  parameter longint unsigned MAX_TEXT_LEN = cst_pkg::DEF_MAX_TEXT_LEN
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cst_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cst_pkg::out_item_t out_data
);
  import cst_pkg::*;
  `include "assert_macros.svh"

  q_push_t fe_push;
  q_head_t q_head;
  logic    q_full;
  logic    q_pop;

  // Stall the source only when the run queue has no room for another item's tokens.
  assign in_stall = q_full;

  // Front end: classify each byte, step the lexer, and bundle the tokens it raises.
  cst_front #(
    .MAX_TEXT_LEN(MAX_TEXT_LEN)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (fe_push)
  );

  // Decouple lexing from delivery; only non-empty runs are queued.
  cst_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (fe_push),
    .pop    (q_pop),
    .q_head (q_head),
    .full   (q_full)
  );

  // Back end: unpack each run onto the output register, one token per cycle unless out_stall.
  cst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A run enters the queue only for an accepted item.
  `ASSERT_CLK(a_push_on_accept, fe_push.push |-> (in_valid && !in_stall), "push without accept")
  // Queued runs always carry at least one token.
  `ASSERT_CLK(a_run_nonempty, fe_push.push |-> (fe_push.run.count != 2'd0), "empty run queued")
  // The rest of a run follows directly after a token that is not the last of it.
  `ASSERT_CLK(a_run_contiguous,
              (out_valid && !out_stall && !out_data.last_of_run) |=> out_valid,
              "gap inside a run")
  // Reset empties the output register.
  `ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "output valid after reset")

endmodule
